### design/sld_pkg.sv
// shared types and constants of the sync-word length-prefixed deframer
`default_nettype none

package sld_pkg;

  // apb address width: one word register, plus one bit to tell writes past it
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // word index of the sync word register within the apb map
  localparam logic REG_SYNC_WORD = 1'b0;

  localparam logic [31:0] SYNC_RESET = 32'h0000_01A5;

  // header byte positions after the sync word
  localparam logic [3:0] HDR_LEN_LO = 4'd1;
  localparam logic [3:0] HDR_LEN_HI = 4'd2;
  localparam logic [3:0] HDR_LAST   = 4'd11;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EMPTY   = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       kind;
    logic       frame_first;
    logic       frame_last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

`default_nettype wire

### design/sld_if.sv
// stream channel interfaces for input bytes and deframed results
`default_nettype none

interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       kind;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output payload_byte, output kind, output frame_first,
                  output frame_last, input ready);
  modport sink (input valid, input payload_byte, input kind, input frame_first,
                input frame_last, output ready);
endinterface

`default_nettype wire

### design/sync_length_deframer_top.sv
// top level of the sync-word length-prefixed deframer with apb register port
`default_nettype none

// Byte-stream deframer. Bytes arrive on in_i, one per transfer, and the block
// hunts for the 32-bit sync word (first byte received is the high byte; reset
// value 0x1A5, written through the apb port at byte address 0). The twelve
// header bytes after it are consumed: byte 0 ignored, bytes 1 and 2 the
// little-endian payload length, bytes 3 to 11 ignored. The payload bytes then
// leave on out_o with kind 0, frame_first on the first and frame_last on the
// last. A zero length gives a single result with kind 1 and a zero byte on
// the last header byte, and the hunt starts again with the shift register set
// to all ones, as it is after every frame. If the sync word is all ones, the
// first byte after a frame counts as header byte zero. The block takes one
// byte per clock while the skid entry is free: all parsing for a byte is
// done in the cycle it is accepted and its result goes into a register of the
// two-entry output stage, which keeps on accepting input bytes while a
// result waits; input stalls only when both entries are full. The apb port
// has no wait states; configure it only while the block is idle.

module sync_length_deframer_top import sld_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  sld_in_if.sink                  in_i,
  sld_out_if.source               out_o
);

  logic [31:0] sync_word_q;
  logic        reg_sel;
  logic        acc;
  logic        space;
  res_t        res;
  out_t        out_data;

  // word address select: one register, anything past it reads as zero
  assign reg_sel = (paddr[2] == REG_SYNC_WORD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? sync_word_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SYNC_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      sync_word_q <= pwdata;
    end
  end

  // input transfer whenever the skid entry is free
  assign in_i.ready = space;
  assign acc        = in_i.valid && space;

  sld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (in_i.data_byte),
    .sync_word_i (sync_word_q),
    .res_o       (res)
  );

  sld_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .space_o     (space),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

  assign out_o.payload_byte = out_data.payload_byte;
  assign out_o.kind         = out_data.kind;
  assign out_o.frame_first  = out_data.frame_first;
  assign out_o.frame_last   = out_data.frame_last;

  a_empty_has_no_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_EMPTY) |->
      (out_o.payload_byte == '0 && !out_o.frame_first && !out_o.frame_last))
    else $error("empty-frame result carries payload marks");

  a_result_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> acc)
    else $error("result produced without an input transfer");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && reg_sel) |-> !acc)
    else $error("sync word written during an input transfer");

endmodule

`default_nettype wire

### design/sld_core.sv
// deframer state machine: sync hunt, header parse and payload pass-through
`default_nettype none

module sld_core import sld_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] sync_word_i,
  output res_t             res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] left_q, left_d;

  logic [31:0] shifted;
  logic        held_match;
  logic        new_match;
  logic        hdr_done;
  logic        pay_last;

  assign shifted    = {shift_q[23:0], data_byte_i};
  assign held_match = (shift_q == sync_word_i);
  assign new_match  = (shifted == sync_word_i);
  assign hdr_done   = (hcnt_q >= HDR_LAST);
  assign pay_last   = (left_q <= 16'd1);

  // hunt shift, header count and length bookkeeping
  always_comb begin
    shift_d  = shift_q;
    hcnt_d   = hcnt_q;
    len_lo_d = len_lo_q;
    left_d   = left_q;
    case (phase_q)
      PH_HEADER: begin
        if (hcnt_q == HDR_LEN_LO) begin
          len_lo_d = data_byte_i;
        end
        if (hcnt_q == HDR_LEN_HI) begin
          left_d = {data_byte_i, len_lo_q};
        end
        if (hdr_done) begin
          hcnt_d = '0;
          if (left_q == '0) begin
            shift_d = '1;
          end
        end else begin
          hcnt_d = hcnt_q + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        hcnt_d = 4'd1;
        left_d = left_q - 16'd1;
        if (pay_last) begin
          shift_d = '1;
          hcnt_d  = '0;
        end
      end
      default: begin
        if (held_match) begin
          // match already held: this byte is header byte zero
          hcnt_d = 4'd1;
        end else begin
          shift_d = shifted;
          hcnt_d  = '0;
        end
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_done) begin
          phase_d = (left_q == '0) ? PH_HUNT : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_last) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = (held_match || new_match) ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_done && left_q == '0) begin
          res_o.valid     = acc_i;
          res_o.data.kind = KIND_EMPTY;
        end
      end
      PH_PAYLOAD: begin
        res_o.valid             = acc_i;
        res_o.data.payload_byte = data_byte_i;
        res_o.data.kind         = KIND_PAYLOAD;
        res_o.data.frame_first  = (hcnt_q == '0);
        res_o.data.frame_last   = pay_last;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      shift_q  <= '1;
      hcnt_q   <= '0;
      len_lo_q <= '0;
      left_q   <= '0;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      hcnt_q   <= hcnt_d;
      len_lo_q <= len_lo_d;
      left_q   <= left_d;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_header_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> hcnt_q <= HDR_LAST)
    else $error("header count beyond last header byte");

  a_hunt_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> hcnt_q == '0)
    else $error("header count not cleared while hunting");

  a_empty_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.kind == KIND_EMPTY) |=> (phase_q == PH_HUNT && shift_q == '1))
    else $error("empty frame did not re-arm the hunt");

endmodule

`default_nettype wire

### design/sld_obuf.sv
// two-entry result buffer: output register plus skid register
`default_nettype none

module sld_obuf import sld_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire res_t push_i,
  output logic      space_o,
  output logic      out_valid_o,
  output out_t      out_data_o,
  input  wire logic out_ready_i
);

  logic out_vld_q, skid_vld_q;
  out_t out_q, skid_q;
  logic take;

  assign take        = out_vld_q && out_ready_i;
  assign space_o     = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (push_i.valid) begin
      if (out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      if (out_vld_q && !out_ready_i) begin
        skid_q <= push_i.data;
      end else begin
        out_q <= push_i.data;
      end
    end else if (take && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && skid_vld_q))
    else $error("result pushed into full buffer");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_ready_i) |=> (out_vld_q && !skid_vld_q && out_q == $past(skid_q)))
    else $error("skid entry not moved to output register");

endmodule

`default_nettype wire

### tb/sld_checker.sv
// checker for the deframer: follows the apb, byte and result channels, predicts and compares
module sld_checker
  import sld_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  input  wire logic [PDATA_W-1:0] prdata,
  input  wire logic               pready,
  input  wire logic               byte_valid,
  input  wire logic               byte_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               res_valid,
  input  wire logic               res_ready,
  input  wire logic [7:0]         payload_byte,
  input  wire logic               kind,
  input  wire logic               frame_first,
  input  wire logic               frame_last,
  output int unsigned             fail_count,
  output int unsigned             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic [31:0] sync_reg;
  logic [31:0] hunt_shift;
  phase_e      parse_phase;
  logic [3:0]  hdr_count;
  logic [7:0]  len_low;
  logic [15:0] bytes_left;

  out_t        payload_due[$];
  int unsigned fails  = 0;
  int unsigned queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  function automatic out_t make_result(input logic [7:0] b, input logic k,
                                       input logic f, input logic l);
    out_t r;
    r.payload_byte = b;
    r.kind         = k;
    r.frame_first  = f;
    r.frame_last   = l;
    return r;
  endfunction

  task automatic restart_hunt();
    hunt_shift  = '1;
    parse_phase = PH_HUNT;
    hdr_count   = '0;
  endtask

  task automatic take_header_byte(input logic [7:0] b);
    logic [3:0] n;
    n = hdr_count;
    if (n == HDR_LEN_LO) begin
      len_low = b;
    end else if (n == HDR_LEN_HI) begin
      bytes_left = {b, len_low};
    end
    if (n >= HDR_LAST) begin
      if (bytes_left == '0) begin
        // zero length: one empty-frame result, then hunt again
        payload_due.push_back(make_result(8'h00, KIND_EMPTY, 1'b0, 1'b0));
        restart_hunt();
      end else begin
        parse_phase = PH_PAYLOAD;
        hdr_count   = '0;
      end
    end else begin
      hdr_count = n + 4'd1;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic first_byte;
    logic last_byte;
    case (parse_phase)
      PH_HEADER: begin
        take_header_byte(b);
      end
      PH_PAYLOAD: begin
        first_byte = (hdr_count == '0);
        last_byte  = (bytes_left <= 16'd1);
        payload_due.push_back(make_result(b, KIND_PAYLOAD, first_byte, last_byte));
        hdr_count  = 4'd1;
        bytes_left = bytes_left - 16'd1;
        if (last_byte) restart_hunt();
      end
      default: begin
        // a match already held means this byte is header byte zero
        if (hunt_shift == sync_reg) begin
          parse_phase = PH_HEADER;
          hdr_count   = '0;
          take_header_byte(b);
        end else begin
          hunt_shift = {hunt_shift[23:0], b};
          if (hunt_shift == sync_reg) begin
            parse_phase = PH_HEADER;
            hdr_count   = '0;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      sync_reg   = SYNC_RESET;
      len_low    = '0;
      bytes_left = '0;
      restart_hunt();
      payload_due.delete();
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_SYNC_WORD) begin
        if (pwrite) begin
          sync_reg = pwdata;
        end else if (prdata !== sync_reg) begin
          $error("sync_word: expected %0h, got %0h", sync_reg, prdata);
          fails++;
        end
      end
      if (res_valid && res_ready) begin
        if (payload_due.size() == 0) begin
          $error("result with none due: payload_byte %0h kind %0b", payload_byte, kind);
          fails++;
        end else begin
          want = payload_due.pop_front();
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("kind", 8'(want.kind), 8'(kind));
          check_field("frame_first", 8'(want.frame_first), 8'(frame_first));
          check_field("frame_last", 8'(want.frame_last), 8'(frame_last));
        end
      end
      if (byte_valid && byte_ready) deframe_byte(data_byte);
    end
    queued = payload_due.size();
  end

endmodule

### tb/sync_length_deframer_top_test.sv
// top of the deframer testbench: clock, reset, byte stimulus, register set-up and verdict
module sync_length_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sld_pkg::*;

  // byte address of the sync word register
  localparam logic [PADDR_W-1:0] SYNC_ADDR = {REG_SYNC_WORD, 2'b00};
  // bytes per setting of the sync word (six settings in all)
  localparam int unsigned PHASE_BYTES  = 300;
  // long hold-off of the result side, long enough to fill the output stage
  localparam int unsigned HOLD_CYCLES  = 60;
  // the result is registered in the output stage; spare cycles once all have come back
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sld_in_if  byte_ch ();
  sld_out_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // sync word currently programmed, so frames can be built around it
  logic [31:0] cur_sync;
  int unsigned bytes_sent;
  // random idling on the byte side and the result side
  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  // request for one long hold-off on the result side
  bit          hold_req = 1'b0;

  sync_length_deframer_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (byte_ch),
    .out_o   (res_ch)
  );

  sld_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_valid   (byte_ch.valid),
    .byte_ready   (byte_ch.ready),
    .data_byte    (byte_ch.data_byte),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .payload_byte (res_ch.payload_byte),
    .kind         (res_ch.kind),
    .frame_first  (res_ch.frame_first),
    .frame_last   (res_ch.frame_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a correct run finishes far inside this
  initial begin
    #1_000_000;
    $display("sync_length_deframer_top: mismatch");
    $finish;
  end

  // result side: ready high by default, short random stalls, and a long
  // hold-off on request while the byte side keeps offering
  initial begin
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one byte and wait for its transfer; an idle burst may come first.
  // called at a rising edge, returns at the edge of the transfer
  task automatic push_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] filler(input bit rand_fill, input logic [7:0] fill);
    return rand_fill ? 8'($urandom) : fill;
  endfunction

  // one frame: sync word (high byte first) unless a match is already held,
  // one skipped byte, little-endian length, nine skipped bytes, payload
  task automatic send_frame(input bit with_sync, input logic [15:0] len,
                            input bit rand_fill, input logic [7:0] fill);
    int i;
    if (with_sync) begin
      for (i = 3; i >= 0; i--) push_byte(cur_sync[8*i +: 8]);
    end
    push_byte(filler(rand_fill, fill));
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    repeat (9) push_byte(filler(rand_fill, fill));
    // long frames get the long hold-off so the input side backs up
    if (stall_on && len >= 16'd40) hold_req = 1'b1;
    for (i = 0; i < int'(len); i++) push_byte(filler(rand_fill, fill));
  endtask

  // hunting noise never carries the top sync byte, so a frame that follows
  // cannot lock on early for repeated-byte sync words
  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == cur_sync[31:24]);
      push_byte(b);
    end
  endtask

  // broken sequence: the first one to three sync bytes, then noise
  task automatic send_broken();
    int i;
    int cut;
    cut = $urandom_range(1, 3);
    for (i = 3; i > 3 - cut; i--) push_byte(cur_sync[8*i +: 8]);
    send_noise($urandom_range(1, 3));
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 16'd0;
    if (r == 15) return 16'($urandom_range(40, 120));
    return 16'($urandom_range(1, 24));
  endfunction

  // random frames with noise and broken sequences between them; with an
  // all-ones sync word every byte after a frame is header, so no noise
  task automatic run_frames(input int unsigned target);
    bit held;
    held = (cur_sync == 32'hFFFF_FFFF);
    while (bytes_sent < target) begin
      if (!held && $urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
      if (!held && $urandom_range(0, 7) == 0) send_broken();
      send_frame(!held, pick_len(), 1'b1, 8'h00);
    end
  endtask

  // stop offering and wait until every due result has come back
  task automatic drain(input int unsigned spare);
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (spare) @(posedge clk);
  endtask

  // apb setup then access phase; psel and penable are dropped before it returns
  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SYNC_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write the sync word while idle and read it back
  task automatic set_sync(input logic [31:0] value);
    drain(DRAIN_CYCLES);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    cur_sync = value;
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cur_sync          = SYNC_RESET;
    bytes_sent        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty frame, then a one-byte frame (first and last together),
    // with all-zero and all-ones filler
    send_frame(1'b1, 16'h0000, 1'b0, 8'h00);
    send_frame(1'b1, 16'h0001, 1'b0, 8'hFF);
    run_frames(PHASE_BYTES);

    // all-ones sync word: the match is held after every frame, so each
    // frame starts straight with its header
    set_sync(32'hFFFF_FFFF);
    send_frame(1'b0, 16'h0002, 1'b0, 8'h00);
    send_frame(1'b0, 16'h0000, 1'b0, 8'hFF);
    run_frames(2 * PHASE_BYTES);

    // all-zero sync word, the other extreme
    set_sync(32'h0000_0000);
    run_frames(3 * PHASE_BYTES);

    // random sync word; one frame with a length above 255
    set_sync($urandom);
    send_frame(1'b1, 16'h012C, 1'b1, 8'h00);
    run_frames(4 * PHASE_BYTES);

    set_sync($urandom);
    run_frames(5 * PHASE_BYTES);

    // back to the reset value, with no idling on either side
    set_sync(SYNC_RESET);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_frames(6 * PHASE_BYTES);

    drain(TAIL_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_length_deframer_top: match");
    end else begin
      $display("sync_length_deframer_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
design/sld_pkg.sv
design/sld_if.sv
design/sld_core.sv
design/sld_obuf.sv
design/sync_length_deframer_top.sv
tb/sld_checker.sv
tb/sync_length_deframer_top_test.sv
